// ===== rtl/tbs_pkg.sv =====
// shared constants, types and width helpers for the barycentric shader
`timescale 1ns / 1ps

package tbs_pkg;

	localparam int PIXEL_W     = 10;
	localparam int VERTEX_W    = 14;
	localparam int CHAN_W      = 8;
	localparam int COLOUR_W    = 3 * CHAN_W;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = COLOUR_W;
	localparam int IMAGE_SIZE  = 1024;

	// register map
	localparam logic [CFG_INDEX_W-1:0] REG_HUE_X      = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_HUE_Y      = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_WHITE_X    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_WHITE_Y    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_BLACK_X    = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_BLACK_Y    = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_HUE_COLOUR = 3'd6;

	localparam logic [COLOUR_W-1:0] HUE_COLOUR_RESET = 24'hFF0000;

	// per-beat control that rides along the pipeline
	typedef struct packed {
		logic valid;
		logic reject;
		logic neg_h;
		logic neg_w;
	} ctl_t;

	typedef struct packed {
		logic              inside_res;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} shade_t;

	// signed width of a centre-minus-vertex difference
	function automatic int diff_width(input int coord_frac_bits);
		int cw;
		cw = PIXEL_W + coord_frac_bits;
		return ((cw > VERTEX_W) ? cw : VERTEX_W) + 1;
	endfunction

	// magnitude width of a numerator or of the area denominator
	function automatic int mag_width(input int coord_frac_bits);
		return 2 * diff_width(coord_frac_bits);
	endfunction

endpackage

// ===== rtl/tbs_pixel_if.sv =====
// pixel coordinate channel
`timescale 1ns / 1ps

interface tbs_pixel_if import tbs_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [PIXEL_W-1:0] pixel_x;
	logic [PIXEL_W-1:0] pixel_y;

	modport source (output valid, output pixel_x, output pixel_y, input ready);
	modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

// ===== rtl/tbs_shade_if.sv =====
// shaded pixel result channel
`timescale 1ns / 1ps

interface tbs_shade_if import tbs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              inside_res;
	logic [CHAN_W-1:0] red;
	logic [CHAN_W-1:0] green;
	logic [CHAN_W-1:0] blue;

	modport source (output valid, output inside_res, output red, output green, output blue,
		input ready);
	modport sink   (input valid, input inside_res, input red, input green, input blue,
		output ready);
endinterface

// ===== rtl/triangle_barycentric_shader.sv =====
// top level: barycentric triangle shader with config registers and output skid buffer
// an accepted pixel beat passes the front end, the divider, the back end and the output register to its result beat
// throughput: one pixel per cycle while the skid entry is free; the divider retires one quotient bit per stage
// backpressure freezes the whole pipeline only once the skid entry behind the output fills
// reset: valid bits clear so the buffers are empty, vertices go to 0 and the hue colour to pure red
`timescale 1ns / 1ps

module triangle_barycentric_shader import tbs_pkg::*; #(
	parameter int COORD_FRAC_BITS  = 4,
	parameter int WEIGHT_FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	tbs_pixel_if.sink              pixel,
	tbs_shade_if.source            shade
);

	localparam int MW = mag_width(COORD_FRAC_BITS);
	localparam int QB = WEIGHT_FRAC_BITS + 1;

	// configuration registers
	logic [VERTEX_W-1:0] vertex_hue_x_q, vertex_hue_y_q;
	logic [VERTEX_W-1:0] vertex_white_x_q, vertex_white_y_q;
	logic [VERTEX_W-1:0] vertex_black_x_q, vertex_black_y_q;
	logic [COLOUR_W-1:0] hue_colour_q;

	// pipeline interconnect
	logic          en;
	ctl_t          ctl_numer, ctl_div;
	logic [MW-1:0] mag_h, mag_w, mag_d;
	logic [QB-1:0] q_h, q_w;
	logic          shd_valid;
	shade_t        shd_res;

	// output register plus one skid entry
	logic   out_v_q, skid_v_q;
	shade_t out_q, skid_q;
	logic   push, pop;

	// the user lands config writes only while the pipeline is drained, unchecked here; stages read them live
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_hue_x_q   <= '0;
			vertex_hue_y_q   <= '0;
			vertex_white_x_q <= '0;
			vertex_white_y_q <= '0;
			vertex_black_x_q <= '0;
			vertex_black_y_q <= '0;
			hue_colour_q     <= HUE_COLOUR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HUE_X:      vertex_hue_x_q   <= cfg_data[VERTEX_W-1:0];
				REG_HUE_Y:      vertex_hue_y_q   <= cfg_data[VERTEX_W-1:0];
				REG_WHITE_X:    vertex_white_x_q <= cfg_data[VERTEX_W-1:0];
				REG_WHITE_Y:    vertex_white_y_q <= cfg_data[VERTEX_W-1:0];
				REG_BLACK_X:    vertex_black_x_q <= cfg_data[VERTEX_W-1:0];
				REG_BLACK_Y:    vertex_black_y_q <= cfg_data[VERTEX_W-1:0];
				REG_HUE_COLOUR: hue_colour_q     <= cfg_data[COLOUR_W-1:0];
				default: ;  // unmapped index, write dropped
			endcase
		end
	end

	// every stage advances together while the skid entry is free
	assign en          = !skid_v_q;
	assign pixel.ready = en;

	// centre, edge functions, area and their magnitudes (4 stages)
	tbs_numer #(
		.COORD_FRAC_BITS(COORD_FRAC_BITS)
	) u_numer (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (pixel.valid),
		.pixel_x  (pixel.pixel_x),
		.pixel_y  (pixel.pixel_y),
		.hue_x    (vertex_hue_x_q),
		.hue_y    (vertex_hue_y_q),
		.white_x  (vertex_white_x_q),
		.white_y  (vertex_white_y_q),
		.black_x  (vertex_black_x_q),
		.black_y  (vertex_black_y_q),
		.ctl_s4   (ctl_numer),
		.mag_h_s4 (mag_h),
		.mag_w_s4 (mag_w),
		.mag_d_s4 (mag_d)
	);

	// rounded scaled quotients; overflow marks the beat outside (1 + WEIGHT_FRAC_BITS + 1 stages)
	tbs_div #(
		.WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS),
		.MAG_W           (MW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_in  (ctl_numer),
		.mag_h   (mag_h),
		.mag_w   (mag_w),
		.mag_d   (mag_d),
		.ctl_out (ctl_div),
		.q_h     (q_h),
		.q_w     (q_w)
	);

	// signs, tolerance test and colour blend (4 stages)
	tbs_shade #(
		.WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
	) u_shade (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.ctl_in     (ctl_div),
		.q_h        (q_h),
		.q_w        (q_w),
		.hue_colour (hue_colour_q),
		.valid_s4   (shd_valid),
		.res_s4     (shd_res)
	);

	// a finished beat leaves the last stage whenever the pipeline advances
	assign push = en && shd_valid;
	assign pop  = out_v_q && shade.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || pop) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= push;
			end
		end else if (push) begin
			// output stalled: park the arriving beat
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || pop) begin
			if (skid_v_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= shd_res;
			end
		end else if (push) begin
			skid_q <= shd_res;
		end
	end

	assign shade.valid      = out_v_q;
	assign shade.inside_res = out_q.inside_res;
	assign shade.red        = out_q.red;
	assign shade.green      = out_q.green;
	assign shade.blue       = out_q.blue;

	// skid entry is only ever occupied behind a held output beat
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry holds a beat while the output register is empty");

	// skid fills only after the output was offered and refused
	a_skid_fill_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && !shade.ready))
		else $error("skid entry filled without an output stall");

	// outside pixels carry no colour
	a_outside_black: assert property (@(posedge clk) disable iff (!arst_n)
		(shade.valid && !shade.inside_res) |->
			(shade.red == '0 && shade.green == '0 && shade.blue == '0))
		else $error("outside pixel has nonzero colour");

endmodule

// ===== rtl/tbs_numer.sv =====
// front end: pixel centre, edge products, numerators and area, magnitudes and signs
`timescale 1ns / 1ps

module tbs_numer import tbs_pkg::*; #(
	parameter int COORD_FRAC_BITS = 4,
	localparam int DW = diff_width(COORD_FRAC_BITS),
	localparam int MW = 2 * DW
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [PIXEL_W-1:0]  pixel_x,
	input  logic [PIXEL_W-1:0]  pixel_y,
	input  logic [VERTEX_W-1:0] hue_x,
	input  logic [VERTEX_W-1:0] hue_y,
	input  logic [VERTEX_W-1:0] white_x,
	input  logic [VERTEX_W-1:0] white_y,
	input  logic [VERTEX_W-1:0] black_x,
	input  logic [VERTEX_W-1:0] black_y,
	output ctl_t                ctl_s4,
	output logic [MW-1:0]       mag_h_s4,
	output logic [MW-1:0]       mag_w_s4,
	output logic [MW-1:0]       mag_d_s4
);

	localparam int CW = PIXEL_W + COORD_FRAC_BITS;
	localparam logic [COORD_FRAC_BITS-1:0] HALF = COORD_FRAC_BITS'(1) << (COORD_FRAC_BITS - 1);

	logic [CW-1:0] cx, cy;
	logic          oob;
	ctl_t          ctl_in, ctl_s1, ctl_s2, ctl_s3, ctl_next4;

	logic signed [DW-1:0] dcx_s1, dcy_s1;
	logic signed [DW-1:0] e_wb_y_s1, e_bw_x_s1, e_bh_y_s1, e_hb_x_s1, e_hb_y_s1;
	logic signed [MW-1:0] p_h1_s2, p_h2_s2, p_w1_s2, p_w2_s2, p_d1_s2, p_d2_s2;
	logic signed [MW:0]   n_h_s3, n_w_s3, n_d_s3;

	assign cx  = {pixel_x, HALF};
	assign cy  = {pixel_y, HALF};
	assign oob = (32'(pixel_x) >= 32'(IMAGE_SIZE)) || (32'(pixel_y) >= 32'(IMAGE_SIZE));

	always_comb begin
		ctl_in        = '0;
		ctl_in.valid  = in_valid;
		ctl_in.reject = oob;
	end

	always_comb begin
		ctl_next4        = ctl_s3;
		ctl_next4.reject = ctl_s3.reject || (n_d_s3 == '0);
		ctl_next4.neg_h  = n_h_s3[MW] ^ n_d_s3[MW];
		ctl_next4.neg_w  = n_w_s3[MW] ^ n_d_s3[MW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_next4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: differences against the black corner
			dcx_s1    <= $signed(DW'(cx)) - $signed(DW'(black_x));
			dcy_s1    <= $signed(DW'(cy)) - $signed(DW'(black_y));
			e_wb_y_s1 <= $signed(DW'(white_y)) - $signed(DW'(black_y));
			e_bw_x_s1 <= $signed(DW'(black_x)) - $signed(DW'(white_x));
			e_bh_y_s1 <= $signed(DW'(black_y)) - $signed(DW'(hue_y));
			e_hb_x_s1 <= $signed(DW'(hue_x)) - $signed(DW'(black_x));
			e_hb_y_s1 <= $signed(DW'(hue_y)) - $signed(DW'(black_y));
			// s2: products
			p_h1_s2 <= MW'(e_wb_y_s1) * MW'(dcx_s1);
			p_h2_s2 <= MW'(e_bw_x_s1) * MW'(dcy_s1);
			p_w1_s2 <= MW'(e_bh_y_s1) * MW'(dcx_s1);
			p_w2_s2 <= MW'(e_hb_x_s1) * MW'(dcy_s1);
			p_d1_s2 <= MW'(e_wb_y_s1) * MW'(e_hb_x_s1);
			p_d2_s2 <= MW'(e_bw_x_s1) * MW'(e_hb_y_s1);
			// s3: sums
			n_h_s3 <= (MW+1)'(p_h1_s2) + (MW+1)'(p_h2_s2);
			n_w_s3 <= (MW+1)'(p_w1_s2) + (MW+1)'(p_w2_s2);
			n_d_s3 <= (MW+1)'(p_d1_s2) + (MW+1)'(p_d2_s2);
			// s4: magnitudes
			mag_h_s4 <= MW'(n_h_s3[MW] ? -n_h_s3 : n_h_s3);
			mag_w_s4 <= MW'(n_w_s3[MW] ? -n_w_s3 : n_w_s3);
			mag_d_s4 <= MW'(n_d_s3[MW] ? -n_d_s3 : n_d_s3);
		end
	end

endmodule

// ===== rtl/tbs_div.sv =====
// pipelined restoring divider, one quotient bit per stage, both weights share the divisor
`timescale 1ns / 1ps

module tbs_div import tbs_pkg::*; #(
	parameter int WEIGHT_FRAC_BITS = 16,
	parameter int MAG_W = 30,
	localparam int QB = WEIGHT_FRAC_BITS + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  ctl_t             ctl_in,
	input  logic [MAG_W-1:0] mag_h,
	input  logic [MAG_W-1:0] mag_w,
	input  logic [MAG_W-1:0] mag_d,
	output ctl_t             ctl_out,
	output logic [QB-1:0]    q_h,
	output logic [QB-1:0]    q_w
);

	localparam int RW = MAG_W + WEIGHT_FRAC_BITS + 1;

	logic [RW-1:0] num_h, num_w, den_top;
	ctl_t          ctl_prep;

	ctl_t             ctl_s   [0:QB];
	logic [RW-1:0]    rem_h_s [0:QB-1];
	logic [RW-1:0]    rem_w_s [0:QB-1];
	logic [MAG_W-1:0] den_s   [0:QB-1];
	logic [QB-1:0]    quo_h_s [0:QB];
	logic [QB-1:0]    quo_w_s [0:QB];

	// dividend carries the half-divisor for round to nearest
	assign num_h   = (RW'(mag_h) << WEIGHT_FRAC_BITS) + RW'(mag_d >> 1);
	assign num_w   = (RW'(mag_w) << WEIGHT_FRAC_BITS) + RW'(mag_d >> 1);
	assign den_top = RW'(mag_d) << QB;

	// a quotient of two or more can never be inside
	always_comb begin
		ctl_prep        = ctl_in;
		ctl_prep.reject = ctl_in.reject || (num_h >= den_top) || (num_w >= den_top);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else if (en) begin
			ctl_s[0] <= ctl_prep;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_h_s[0] <= num_h;
			rem_w_s[0] <= num_w;
			den_s[0]   <= mag_d;
			quo_h_s[0] <= '0;
			quo_w_s[0] <= '0;
		end
	end

	for (genvar i = 0; i < QB; i++) begin : g_bit
		localparam int K = QB - 1 - i;
		logic [RW-1:0] dsh;
		logic          ge_h, ge_w;

		assign dsh  = RW'(den_s[i]) << K;
		assign ge_h = rem_h_s[i] >= dsh;
		assign ge_w = rem_w_s[i] >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[i+1] <= '0;
			end else if (en) begin
				ctl_s[i+1] <= ctl_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				quo_h_s[i+1] <= quo_h_s[i] | (ge_h ? (QB'(1) << K) : '0);
				quo_w_s[i+1] <= quo_w_s[i] | (ge_w ? (QB'(1) << K) : '0);
			end
		end

		if (i < QB - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_h_s[i+1] <= ge_h ? (rem_h_s[i] - dsh) : rem_h_s[i];
					rem_w_s[i+1] <= ge_w ? (rem_w_s[i] - dsh) : rem_w_s[i];
					den_s[i+1]   <= den_s[i];
				end
			end
		end
	end

	assign ctl_out = ctl_s[QB];
	assign q_h     = quo_h_s[QB];
	assign q_w     = quo_w_s[QB];

endmodule

// ===== rtl/tbs_shade.sv =====
// back end: signed weights, inside test, colour blend, clamp and round
`timescale 1ns / 1ps

module tbs_shade import tbs_pkg::*; #(
	parameter int WEIGHT_FRAC_BITS = 16,
	localparam int QB = WEIGHT_FRAC_BITS + 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  ctl_t                ctl_in,
	input  logic [QB-1:0]       q_h,
	input  logic [QB-1:0]       q_w,
	input  logic [COLOUR_W-1:0] hue_colour,
	output logic                valid_s4,
	output shade_t              res_s4
);

	localparam int W    = WEIGHT_FRAC_BITS;
	localparam int WW   = W + 2;
	localparam int WK_W = W + 3;
	localparam int MP_W = WW + CHAN_W + 1;
	localparam int VW   = MP_W + 1;
	localparam int TOL  = (1 << W) / 1000;

	localparam logic signed [WK_W-1:0] WEIGHT_ONE = WK_W'(1 << W);
	localparam logic signed [WK_W-1:0] NEG_TOL    = WK_W'(-TOL);
	localparam logic [W+7:0]           TOP_U      = {8'd255, {W{1'b0}}};
	localparam logic signed [VW-1:0]   V_TOP      = $signed(VW'(TOP_U));
	localparam logic [W+7:0]           HALF_U     = (W+8)'(1) << (W - 1);

	ctl_t                 ctl_s1;
	logic signed [WW-1:0] wh_s1, ww_s1;
	logic signed [WK_W-1:0] wk;
	logic                 in_tri;
	logic                 valid_s2, valid_s3;
	logic                 inside_s2, inside_s3;
	logic signed [MP_W-1:0] mh_s2 [0:2];
	logic signed [MP_W-1:0] mw_s2;
	logic signed [VW-1:0]   v_s3  [0:2];
	logic [CHAN_W-1:0]      chan  [0:2];

	assign wk     = WEIGHT_ONE - WK_W'(wh_s1) - WK_W'(ww_s1);
	assign in_tri = !ctl_s1.reject && (WK_W'(wh_s1) >= NEG_TOL) &&
		(WK_W'(ww_s1) >= NEG_TOL) && (wk >= NEG_TOL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1    <= '0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			valid_s4  <= 1'b0;
			inside_s2 <= 1'b0;
			inside_s3 <= 1'b0;
		end else if (en) begin
			ctl_s1    <= ctl_in;
			valid_s2  <= ctl_s1.valid;
			valid_s3  <= valid_s2;
			valid_s4  <= valid_s3;
			inside_s2 <= in_tri;
			inside_s3 <= inside_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wh_s1 <= ctl_in.neg_h ? -$signed(WW'(q_h)) : $signed(WW'(q_h));
			ww_s1 <= ctl_in.neg_w ? -$signed(WW'(q_w)) : $signed(WW'(q_w));
			// white contribution is ww * 255
			mw_s2 <= (MP_W'(ww_s1) <<< CHAN_W) - MP_W'(ww_s1);
			res_s4.inside_res <= inside_s3;
			res_s4.red        <= chan[0];
			res_s4.green      <= chan[1];
			res_s4.blue       <= chan[2];
		end
	end

	// red lane first, blue last
	for (genvar ch = 0; ch < 3; ch++) begin : g_lane
		logic [CHAN_W-1:0] c;
		logic [W+7:0]      clamped, rounded;

		assign c = hue_colour[(2 - ch) * CHAN_W +: CHAN_W];

		always_comb begin
			if (v_s3[ch][VW-1]) begin
				clamped = '0;
			end else if (v_s3[ch] > V_TOP) begin
				clamped = TOP_U;
			end else begin
				clamped = (W+8)'(v_s3[ch]);
			end
			rounded  = clamped + HALF_U;
			chan[ch] = inside_s3 ? rounded[W+7:W] : '0;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				mh_s2[ch] <= MP_W'(wh_s1) * MP_W'($signed({1'b0, c}));
				v_s3[ch]  <= VW'(mh_s2[ch]) + VW'(mw_s2);
			end
		end
	end

endmodule

// ===== tb/tb.sv =====
// self-checking regression bench for the barycentric triangle shader
`timescale 1ns / 1ps

module tb;
	import tbs_pkg::*;

	localparam int COORD_FRAC_BITS  = 4;
	localparam int WEIGHT_FRAC_BITS = 16;
	// pixel beat in to shade beat out, through every register of the shader pipeline
	localparam int LATENCY          = WEIGHT_FRAC_BITS + 11;
	localparam int MAX_CYCLES       = 1000000;
	localparam int PHASES           = 8;
	localparam int PHASE_PIXELS     = 250;
	localparam int FLAT_PIXELS      = 50;
	localparam int VERTEX_MAX       = (1 << VERTEX_W) - 1;

	// fixed point scale of the weights
	localparam longint WEIGHT_ONE = longint'(1) << WEIGHT_FRAC_BITS;
	localparam longint HALF_LSB   = WEIGHT_ONE / 2;
	localparam longint FULL_SCALE = 255 * WEIGHT_ONE;
	// 0.001 in weight units, rounded toward zero; applied as the negative bound -0.001
	localparam longint TOLERANCE  = WEIGHT_ONE / 1000;

	// index 7 has no register behind it
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
	localparam logic [CFG_INDEX_W-1:0] VERTEX_REGS [6] = '{REG_HUE_X, REG_HUE_Y,
		REG_WHITE_X, REG_WHITE_Y, REG_BLACK_X, REG_BLACK_Y};

	typedef enum {ROW_WRITE, ROW_PIXEL} row_kind_t;
	typedef enum {SHAPE_RANDOM, SHAPE_SMALL, SHAPE_CORNERS, SHAPE_FLAT} shape_t;

	// one line of the directed table: a register write or a pixel beat
	typedef struct {
		row_kind_t                kind;
		logic [CFG_INDEX_W-1:0]   idx;
		logic [CFG_DATA_W-1:0]    data;
		logic [PIXEL_W-1:0]       px;
		logic [PIXEL_W-1:0]       py;
		bit                       typed;
		shade_t                   want;
	} stim_row_t;

	// bench copy of the corner and colour registers
	typedef struct {
		logic [VERTEX_W-1:0] hx, hy, wx, wy, bx, by;
		logic [COLOUR_W-1:0] hue;
	} shader_regs_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	tbs_pixel_if pixel_ch ();
	tbs_shade_if shade_ch ();

	shader_regs_t live_regs;
	shade_t       pending_shades[$];
	stim_row_t    directed_rows[$];
	bit           no_idle;
	int           errors;
	int           pixel_beats;
	int           shade_beats;
	int           lit_pixels;
	int           settings_used;

	shape_t phase_shape [PHASES] = '{SHAPE_RANDOM, SHAPE_SMALL, SHAPE_CORNERS, SHAPE_RANDOM,
		SHAPE_FLAT, SHAPE_SMALL, SHAPE_RANDOM, SHAPE_CORNERS};

	triangle_barycentric_shader #(
		.COORD_FRAC_BITS  (COORD_FRAC_BITS),
		.WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixel     (pixel_ch),
		.shade     (shade_ch)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------

	// n * 2^WEIGHT_FRAC_BITS / d, nearest, ties away from zero
	function automatic longint round_ratio(longint num, longint den);
		longint unsigned mag_n, mag_d, q;
		mag_n = (num < 0) ? -num : num;
		mag_d = (den < 0) ? -den : den;
		q = ((mag_n << WEIGHT_FRAC_BITS) + mag_d / 2) / mag_d;
		return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
	endfunction

	// hue weight times the hue channel plus the white weight times 255, clamped and rounded
	function automatic logic [CHAN_W-1:0] blend(longint wh, longint ww,
			logic [CHAN_W-1:0] chan);
		longint v;
		v = wh * longint'(chan) + ww * 255;
		if (v < 0) v = 0;
		if (v > FULL_SCALE) v = FULL_SCALE;
		return CHAN_W'((v + HALF_LSB) >>> WEIGHT_FRAC_BITS);
	endfunction

	function automatic shade_t shade_pixel(logic [PIXEL_W-1:0] px, logic [PIXEL_W-1:0] py);
		longint hx, hy, wx, wy, bx, by, cx, cy, d, nh, nw, wh, ww, wk;
		shade_t r;
		r = '0;
		if (px >= IMAGE_SIZE || py >= IMAGE_SIZE) return r;
		hx = longint'(live_regs.hx);
		hy = longint'(live_regs.hy);
		wx = longint'(live_regs.wx);
		wy = longint'(live_regs.wy);
		bx = longint'(live_regs.bx);
		by = longint'(live_regs.by);
		// sample at the pixel centre, in the same sub-pixel units as the corners
		cx = (longint'(px) << COORD_FRAC_BITS) + (longint'(1) << (COORD_FRAC_BITS - 1));
		cy = (longint'(py) << COORD_FRAC_BITS) + (longint'(1) << (COORD_FRAC_BITS - 1));
		d = (wy - by) * (hx - bx) + (bx - wx) * (hy - by);
		// zero area: nothing can be inside
		if (d == 0) return r;
		nh = (wy - by) * (cx - bx) + (bx - wx) * (cy - by);
		nw = (by - hy) * (cx - bx) + (hx - bx) * (cy - by);
		wh = round_ratio(nh, d);
		ww = round_ratio(nw, d);
		wk = WEIGHT_ONE - wh - ww;
		if (wh < -TOLERANCE || ww < -TOLERANCE || wk < -TOLERANCE) return r;
		r.inside_res = 1'b1;
		r.red   = blend(wh, ww, live_regs.hue[23:16]);
		r.green = blend(wh, ww, live_regs.hue[15:8]);
		r.blue  = blend(wh, ww, live_regs.hue[7:0]);
		return r;
	endfunction

	// ---------------------------------------------------------------
	// directed table rows
	// ---------------------------------------------------------------

	function automatic stim_row_t reg_row(logic [CFG_INDEX_W-1:0] idx,
			logic [CFG_DATA_W-1:0] data);
		stim_row_t row;
		row = '{kind: ROW_WRITE, idx: idx, data: data, px: '0, py: '0, typed: 1'b0,
			want: '0};
		return row;
	endfunction

	// shaded value comes from the predictor
	function automatic stim_row_t pixel_row(int px, int py);
		stim_row_t row;
		row = '{kind: ROW_PIXEL, idx: REG_UNUSED, data: '0, px: PIXEL_W'(px),
			py: PIXEL_W'(py), typed: 1'b0, want: '0};
		return row;
	endfunction

	// plainly outside: all four fields zero
	function automatic stim_row_t outside_row(int px, int py);
		stim_row_t row;
		row = pixel_row(px, py);
		row.typed = 1'b1;
		return row;
	endfunction

	// ---------------------------------------------------------------
	// drivers
	// ---------------------------------------------------------------

	// idle stretch: mostly short, now and then a long one
	function automatic int idle_len();
		if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
		return $urandom_range(1, 3);
	endfunction

	function automatic logic [PIXEL_W-1:0] clamp_pixel(int p);
		if (p < 0) return '0;
		if (p > IMAGE_SIZE - 1) return PIXEL_W'(IMAGE_SIZE - 1);
		return PIXEL_W'(p);
	endfunction

	// one register write; cfg_we is left high so back-to-back writes follow with no idle edge between them
	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			REG_HUE_X:      live_regs.hx  = data[VERTEX_W-1:0];
			REG_HUE_Y:      live_regs.hy  = data[VERTEX_W-1:0];
			REG_WHITE_X:    live_regs.wx  = data[VERTEX_W-1:0];
			REG_WHITE_Y:    live_regs.wy  = data[VERTEX_W-1:0];
			REG_BLACK_X:    live_regs.bx  = data[VERTEX_W-1:0];
			REG_BLACK_Y:    live_regs.by  = data[VERTEX_W-1:0];
			REG_HUE_COLOUR: live_regs.hue = data[COLOUR_W-1:0];
			default: ;
		endcase
	endtask

	// present one pixel beat, hold it until taken, then log what should come back
	task automatic send_pixel(logic [PIXEL_W-1:0] px, logic [PIXEL_W-1:0] py, bit typed,
			shade_t want);
		int gap;
		shade_t expected;
		gap = (no_idle || $urandom_range(0, 1) == 0) ? 0 : idle_len();
		if (gap > 0) begin
			pixel_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel_ch.valid   <= 1'b1;
		pixel_ch.pixel_x <= px;
		pixel_ch.pixel_y <= py;
		do @(posedge clk); while (!pixel_ch.ready);
		expected = typed ? want : shade_pixel(px, py);
		pending_shades.push_back(expected);
		pixel_beats++;
		if (expected.inside_res) lit_pixels++;
	endtask

	// stop sending and let every outstanding shade beat drain
	task automatic wait_idle();
		pixel_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_shades.size() != 0);
	endtask

	// ---------------------------------------------------------------
	// result side: random backpressure and checking
	// ---------------------------------------------------------------

	initial begin
		int stall_left;
		stall_left = 0;
		shade_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
			end else if (no_idle || $urandom_range(0, 2) != 0) begin
				shade_ch.ready <= 1'b1;
				stall_left = $urandom_range(0, 12);
			end else begin
				shade_ch.ready <= 1'b0;
				stall_left = idle_len();
			end
		end
	end

	// a beat moves when valid and ready were both high before this edge
	always @(posedge clk) begin
		shade_t expected;
		if (arst_n && shade_ch.valid && shade_ch.ready) begin
			shade_beats++;
			if (pending_shades.size() == 0) begin
				$error("shade beat with no pixel outstanding: inside_res %0d rgb %02h%02h%02h",
					shade_ch.inside_res, shade_ch.red, shade_ch.green, shade_ch.blue);
				errors++;
			end else begin
				expected = pending_shades.pop_front();
				if (shade_ch.inside_res !== expected.inside_res) begin
					$error("inside_res: expected %0d, got %0d", expected.inside_res,
						shade_ch.inside_res);
					errors++;
				end
				if (shade_ch.red !== expected.red) begin
					$error("red: expected %0d, got %0d", expected.red, shade_ch.red);
					errors++;
				end
				if (shade_ch.green !== expected.green) begin
					$error("green: expected %0d, got %0d", expected.green, shade_ch.green);
					errors++;
				end
				if (shade_ch.blue !== expected.blue) begin
					$error("blue: expected %0d, got %0d", expected.blue, shade_ch.blue);
					errors++;
				end
			end
		end
	end

	// hard stop far beyond the slowest legal run
	initial begin
		repeat (MAX_CYCLES) @(posedge clk);
		$error("timeout with %0d shade beats still outstanding", pending_shades.size());
		$display("triangle_barycentric_shader regression: fail");
		$finish;
	end

	// ---------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------

	initial begin
		stim_row_t row;
		shape_t shape;
		int v[6];
		logic [COLOUR_W-1:0] hue;
		int phase, i, k, s, c, dx, dy, a, b, t, x, y, count;
		int lo_x, hi_x, lo_y, hi_y;

		// every input known from time zero, reset held low
		arst_n           <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_index        <= REG_HUE_X;
		cfg_data         <= '0;
		pixel_ch.valid   <= 1'b0;
		pixel_ch.pixel_x <= '0;
		pixel_ch.pixel_y <= '0;
		live_regs = '{hx: '0, hy: '0, wx: '0, wy: '0, bx: '0, by: '0,
			hue: HUE_COLOUR_RESET};
		no_idle = 1'b0;
		errors = 0;
		pixel_beats = 0;
		shade_beats = 0;
		lit_pixels = 0;
		settings_used = 1;

		// reset state: every corner at the origin, so zero area
		directed_rows.push_back(outside_row(0, 0));
		directed_rows.push_back(outside_row(1023, 1023));
		directed_rows.push_back(outside_row(1023, 0));
		directed_rows.push_back(outside_row(0, 1023));
		// right triangle over the upper-left half; write to a hole in the map,
		// data bits above the corner width must be dropped
		directed_rows.push_back(reg_row(REG_UNUSED, 24'hFFFFFF));
		directed_rows.push_back(reg_row(REG_HUE_X, 24'h000000));
		directed_rows.push_back(reg_row(REG_HUE_Y, 24'hFFC000));
		directed_rows.push_back(reg_row(REG_WHITE_X, 24'hFFFFFF));
		directed_rows.push_back(reg_row(REG_WHITE_Y, 24'h000000));
		directed_rows.push_back(reg_row(REG_BLACK_X, 24'h000000));
		directed_rows.push_back(reg_row(REG_BLACK_Y, 24'h003FFF));
		directed_rows.push_back(reg_row(REG_HUE_COLOUR, 24'hFFFFFF));
		directed_rows.push_back(pixel_row(0, 0));
		directed_rows.push_back(pixel_row(1023, 0));
		directed_rows.push_back(pixel_row(0, 1023));
		directed_rows.push_back(outside_row(1023, 1023));
		directed_rows.push_back(pixel_row(511, 511));
		directed_rows.push_back(pixel_row(512, 511));
		directed_rows.push_back(pixel_row(341, 682));
		// opposite winding, hue dropped to black
		directed_rows.push_back(reg_row(REG_WHITE_X, 24'h000000));
		directed_rows.push_back(reg_row(REG_WHITE_Y, 24'h003FFF));
		directed_rows.push_back(reg_row(REG_BLACK_X, 24'h003FFF));
		directed_rows.push_back(reg_row(REG_BLACK_Y, 24'h000000));
		directed_rows.push_back(reg_row(REG_HUE_COLOUR, 24'h000000));
		directed_rows.push_back(pixel_row(0, 0));
		directed_rows.push_back(pixel_row(100, 900));
		directed_rows.push_back(pixel_row(900, 100));
		directed_rows.push_back(pixel_row(1023, 0));
		// three corners on the left edge: collinear, zero area
		directed_rows.push_back(reg_row(REG_BLACK_X, 24'h000000));
		directed_rows.push_back(reg_row(REG_BLACK_Y, 24'd8000));
		directed_rows.push_back(outside_row(0, 500));
		directed_rows.push_back(outside_row(0, 0));
		directed_rows.push_back(outside_row(512, 512));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the table; register writes only once the pipe has drained
		foreach (directed_rows[r]) begin
			row = directed_rows[r];
			if (row.kind == ROW_WRITE) begin
				if (!cfg_we) begin
					wait_idle();
					settings_used++;
				end
				write_reg(row.idx, row.data);
			end else begin
				if (cfg_we) begin
					cfg_we <= 1'b0;
					@(posedge clk);
				end
				send_pixel(row.px, row.py, row.typed, row.want);
			end
		end

		// random phases, each with a fresh triangle and colour
		for (phase = 0; phase < PHASES; phase++) begin
			shape = phase_shape[phase];
			hue = COLOUR_W'($urandom);
			case (shape)
				SHAPE_RANDOM: begin
					for (k = 0; k < 6; k++) v[k] = $urandom_range(0, VERTEX_MAX);
				end
				SHAPE_SMALL: begin
					// up to 25 pixels across, somewhere in the image
					dx = $urandom_range(0, VERTEX_MAX - 400);
					dy = $urandom_range(0, VERTEX_MAX - 400);
					for (k = 0; k < 3; k++) begin
						v[2*k]   = dx + $urandom_range(0, 400);
						v[2*k+1] = dy + $urandom_range(0, 400);
					end
				end
				SHAPE_CORNERS: begin
					// three of the four image corners, random winding, extreme colours
					s = $urandom_range(0, 3);
					for (k = 0; k < 3; k++) begin
						c = (s + 1 + k) % 4;
						v[2*k]   = (c == 1 || c == 2) ? VERTEX_MAX : 0;
						v[2*k+1] = (c >= 2) ? VERTEX_MAX : 0;
					end
					if ($urandom_range(0, 1)) begin
						{v[0], v[1], v[2], v[3]} = {v[2], v[3], v[0], v[1]};
					end
					hue = (phase < PHASES / 2) ? 24'hFFFFFF : 24'h000000;
				end
				default: begin
					// corners on one line, so zero area
					v[0] = $urandom_range(8000, 8383);
					v[1] = $urandom_range(8000, 8383);
					dx = int'($urandom_range(0, 8000)) - 4000;
					dy = int'($urandom_range(0, 8000)) - 4000;
					v[2] = v[0] + dx;
					v[3] = v[1] + dy;
					v[4] = v[0] + 2 * dx;
					v[5] = v[1] + 2 * dy;
				end
			endcase

			wait_idle();
			settings_used++;
			if ($urandom_range(0, 1)) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
			for (k = 0; k < 6; k++) begin
				write_reg(VERTEX_REGS[k], {(CFG_DATA_W - VERTEX_W)'($urandom),
					VERTEX_W'(v[k])});
			end
			write_reg(REG_HUE_COLOUR, hue);
			cfg_we <= 1'b0;
			@(posedge clk);
			// every third phase runs both sides flat out
			no_idle = (phase % 3 == 2);

			// pixel bounding box of the triangle
			lo_x = VERTEX_MAX;
			hi_x = 0;
			lo_y = VERTEX_MAX;
			hi_y = 0;
			for (k = 0; k < 6; k += 2) begin
				if (v[k] < lo_x) lo_x = v[k];
				if (v[k] > hi_x) hi_x = v[k];
				if (v[k+1] < lo_y) lo_y = v[k+1];
				if (v[k+1] > hi_y) hi_y = v[k+1];
			end
			lo_x = lo_x >> COORD_FRAC_BITS;
			hi_x = hi_x >> COORD_FRAC_BITS;
			lo_y = lo_y >> COORD_FRAC_BITS;
			hi_y = hi_y >> COORD_FRAC_BITS;

			count = (shape == SHAPE_FLAT) ? FLAT_PIXELS : PHASE_PIXELS;
			for (i = 0; i < count; i++) begin
				case ($urandom_range(0, 3))
					0: begin
						// anywhere in the image
						x = $urandom_range(0, IMAGE_SIZE - 1);
						y = $urandom_range(0, IMAGE_SIZE - 1);
					end
					1: begin
						// on or next to an edge, where the tolerance decides
						a = $urandom_range(0, 2);
						b = (a + 1) % 3;
						t = $urandom_range(0, 256);
						x = (v[2*a] * (256 - t) + v[2*b] * t) / 256;
						y = (v[2*a+1] * (256 - t) + v[2*b+1] * t) / 256;
						x = (x >> COORD_FRAC_BITS) + int'($urandom_range(0, 2)) - 1;
						y = (y >> COORD_FRAC_BITS) + int'($urandom_range(0, 2)) - 1;
					end
					default: begin
						x = $urandom_range(lo_x, hi_x);
						y = $urandom_range(lo_y, hi_y);
					end
				endcase
				send_pixel(clamp_pixel(x), clamp_pixel(y), 1'b0, '0);
			end
			no_idle = 1'b0;
		end

		// drain, then give a stray late beat time to show up
		wait_idle();
		repeat (2 * LATENCY) @(posedge clk);

		$display("covered %0d pixel beats under %0d corner and colour settings, %0d shaded",
			pixel_beats, settings_used, lit_pixels);
		$display("%0d shade beats compared, %0d mismatches", shade_beats, errors);
		if (errors == 0 && pending_shades.size() == 0) begin
			$display("triangle_barycentric_shader regression: pass");
		end else begin
			$display("triangle_barycentric_shader regression: fail");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/tbs_pkg.sv
rtl/tbs_pixel_if.sv
rtl/tbs_shade_if.sv
rtl/tbs_numer.sv
rtl/tbs_div.sv
rtl/tbs_shade.sv
rtl/triangle_barycentric_shader.sv
tb/tb.sv
